[design/cfd_pkg.sv]
package cfd_pkg;

   localparam logic [7:0] START_BYTE  = 8'hED;
   localparam logic [7:0] SECOND_BYTE = 8'h01;
   localparam logic [7:0] TAIL_BYTE   = 8'hEE;
   localparam logic [7:0] READ_PAD    = 8'h00;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd98;

   typedef enum logic [2:0] {
      EV_PAYLOAD  = 3'd0,
      EV_READ     = 3'd1,
      EV_WRITE_OK = 3'd2,
      EV_CS_ERROR = 3'd3,
      EV_DISCARD  = 3'd4
   } event_kind_type;

   typedef enum logic [7:0] {
      PH_START    = 8'b0000_0001,
      PH_SECOND   = 8'b0000_0010,
      PH_COMMAND  = 8'b0000_0100,
      PH_LENGTH   = 8'b0000_1000,
      PH_READ     = 8'b0001_0000,
      PH_PAYLOAD  = 8'b0010_0000,
      PH_CHECKSUM = 8'b0100_0000,
      PH_TAIL     = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     command_code;
      logic [7:0]     payload_byte;
      logic [7:0]     payload_index;
      logic [7:0]     payload_length;
   } event_type;

endpackage

[design/command_frame_deframer.sv]
// command frame deframer: one received byte per item, zero or one event per item
// latency: an accepted item is held in the input register, stepped through the parser
//    once the result register is free, and its event is loaded into the result register
// throughput: one item per cycle while rsp_ready holds high; set by the single
//    state machine step between the input register and the result register
// reset: synchronous, active high; parser waits for a start byte, max_payload = 98
module command_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   // byte input
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   // event output
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic [7:0] rsp_payload_length,
   // max_payload register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_payload
);
   import cfd_pkg::*;

   // input register holds one byte ahead of the parser
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] max_payload_ff;

   logic      step;
   logic      out_free;
   logic      event_valid;
   event_type event_data;
   event_type out_data;

   // parser steps when a byte is held and the result slot can take an event
   assign step        = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

   // register is always writable; writes must happen only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            max_payload_ff <= csr_max_payload;
         end
      end
   end

   // byte payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame state machine, checksum and counters
   cfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .max_payload (max_payload_ff),
      .event_valid (event_valid),
      .event_data  (event_data)
   );

   // result register; a byte that makes no event still needs the slot free
   cfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && event_valid),
      .load_data (event_data),
      .out_ready (rsp_ready),
      .free      (out_free),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_event_kind     = out_data.kind;
   assign rsp_command_code   = out_data.command_code;
   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_payload_index  = out_data.payload_index;
   assign rsp_payload_length = out_data.payload_length;

endmodule

[design/cfd_parser.sv]
module cfd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        max_payload,
   output logic              event_valid,
   output cfd_pkg::event_type event_data
);
   import cfd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] checksum_ff, checksum_in;
   logic [7:0] count_ff, count_in;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      checksum_in  = checksum_ff;
      count_in     = count_ff;
      event_valid  = 1'b0;
      event_data.kind           = EV_PAYLOAD;
      event_data.command_code   = command_ff;
      event_data.payload_byte   = 8'd0;
      event_data.payload_index  = 8'd0;
      event_data.payload_length = length_ff;
      unique case (phase_ff)
         PH_START: begin
            if (rx_byte == START_BYTE) phase_in = PH_SECOND;
         end
         PH_SECOND: begin
            phase_in = (rx_byte == SECOND_BYTE) ? PH_COMMAND : PH_START;
         end
         PH_COMMAND: begin
            command_in = rx_byte;
            phase_in   = PH_LENGTH;
         end
         PH_LENGTH: begin
            length_in = rx_byte;
            sum_in    = 8'd0;
            count_in  = 8'd0;
            if (rx_byte == 8'd0) begin
               remaining_in = 8'd1;
               phase_in     = PH_READ;
            end else if (rx_byte > max_payload) begin
               phase_in = PH_START;
            end else begin
               remaining_in = rx_byte;
               phase_in     = PH_PAYLOAD;
            end
         end
         PH_READ: begin
            if (remaining_ff != 8'd0) begin
               remaining_in = 8'd0;
               if (rx_byte != READ_PAD) phase_in = PH_START;
            end else begin
               if (rx_byte == TAIL_BYTE) begin
                  event_valid     = 1'b1;
                  event_data.kind = EV_READ;
               end
               phase_in = PH_START;
            end
         end
         PH_PAYLOAD: begin
            event_valid              = 1'b1;
            event_data.kind          = EV_PAYLOAD;
            event_data.payload_byte  = rx_byte;
            event_data.payload_index = count_ff;
            sum_in       = sum_ff + rx_byte;
            count_in     = count_ff + 8'd1;
            remaining_in = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) phase_in = PH_CHECKSUM;
         end
         PH_CHECKSUM: begin
            checksum_in = rx_byte;
            phase_in    = PH_TAIL;
         end
         PH_TAIL: begin
            event_valid = 1'b1;
            if (sum_ff != checksum_ff) event_data.kind = EV_CS_ERROR;
            else if (rx_byte == TAIL_BYTE) event_data.kind = EV_WRITE_OK;
            else event_data.kind = EV_DISCARD;
            phase_in = PH_START;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         remaining_ff <= 8'd0;
         sum_ff       <= 8'd0;
         command_ff   <= 8'd0;
         length_ff    <= 8'd0;
         checksum_ff  <= 8'd0;
         count_ff     <= 8'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         checksum_ff  <= checksum_in;
         count_ff     <= count_in;
      end
   end

endmodule

[design/cfd_out_reg.sv]
module cfd_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  cfd_pkg::event_type load_data,
   input  logic              out_ready,
   output logic              free,
   output logic              out_valid,
   output cfd_pkg::event_type out_data
);
   import cfd_pkg::*;

   logic      valid_ff, valid_in;
   event_type data_ff;

   // slot frees up when the held item is taken in this cycle
   assign free     = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[tb/tb_command_frame_deframer.sv]
module tb_command_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import cfd_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 4;
   // events pass the input and result registers after the byte; the settle wait covers a byte with no event
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 60;
   localparam int PHASE_BYTES    = 130;
   localparam int WATCHDOG_LIMIT = 2000;

   // ways a generated frame can be spoiled
   typedef enum int {
      FLAW_NONE,
      FLAW_CHECKSUM,
      FLAW_TAIL,
      FLAW_BOTH
   } frame_flaw_type;

   // byte-level frame parser mirror plus the queue of events it predicts
   class frame_event_checker;
      phase_type  phase;
      logic [7:0] remaining;
      logic [7:0] running_sum;
      logic [7:0] frame_cmd;
      logic [7:0] frame_len;
      logic [7:0] rx_checksum;
      logic [7:0] payload_seen;
      logic [7:0] limit;
      event_type  expected_events[$];
      int         mismatches;
      int         expected_total;
      int         events_checked;
      int         kind_count[8];

      function new();
         phase          = PH_START;
         remaining      = '0;
         running_sum    = '0;
         frame_cmd      = '0;
         frame_len      = '0;
         rx_checksum    = '0;
         payload_seen   = '0;
         limit          = MAX_PAYLOAD_RESET;
         mismatches     = 0;
         expected_total = 0;
         events_checked = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void set_max_payload(logic [7:0] value);
         limit = value;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void add_expected(event_kind_type kind, logic [7:0] data, logic [7:0] idx);
         event_type ev;
         ev.kind           = kind;
         ev.command_code   = frame_cmd;
         ev.payload_byte   = data;
         ev.payload_index  = idx;
         ev.payload_length = frame_len;
         expected_events.push_back(ev);
         expected_total++;
      endfunction

      // one accepted rx byte through the parser
      function void note_rx_byte(logic [7:0] b);
         case (phase)
            PH_START: begin
               if (b == START_BYTE) phase = PH_SECOND;
            end
            PH_SECOND: begin
               phase = (b == SECOND_BYTE) ? PH_COMMAND : PH_START;
            end
            PH_COMMAND: begin
               frame_cmd = b;
               phase     = PH_LENGTH;
            end
            PH_LENGTH: begin
               frame_len    = b;
               running_sum  = '0;
               payload_seen = '0;
               if (b == 8'd0) begin
                  remaining = 8'd1;
                  phase     = PH_READ;
               end else if (b > limit) begin
                  phase = PH_START;
               end else begin
                  remaining = b;
                  phase     = PH_PAYLOAD;
               end
            end
            PH_READ: begin
               // remaining 1: waiting for the pad byte, 0: waiting for the tail
               if (remaining != 8'd0) begin
                  remaining = 8'd0;
                  if (b != READ_PAD) phase = PH_START;
               end else begin
                  if (b == TAIL_BYTE) add_expected(EV_READ, 8'd0, 8'd0);
                  phase = PH_START;
               end
            end
            PH_PAYLOAD: begin
               add_expected(EV_PAYLOAD, b, payload_seen);
               running_sum  = running_sum + b;
               payload_seen = payload_seen + 8'd1;
               remaining    = remaining - 8'd1;
               if (remaining == 8'd0) phase = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
               rx_checksum = b;
               phase       = PH_TAIL;
            end
            default: begin
               if (running_sum != rx_checksum) add_expected(EV_CS_ERROR, 8'd0, 8'd0);
               else if (b == TAIL_BYTE) add_expected(EV_WRITE_OK, 8'd0, 8'd0);
               else add_expected(EV_DISCARD, 8'd0, 8'd0);
               phase = PH_START;
            end
         endcase
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(logic [2:0] kind, logic [7:0] command, logic [7:0] data,
                                logic [7:0] idx, logic [7:0] length);
         event_type want;
         if (expected_events.size() == 0) begin
            $display("%t: event expected none actual kind %0d command %0d", $time, kind, command);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         compare_field("event_kind", 8'(want.kind), 8'(kind));
         compare_field("command_code", want.command_code, command);
         compare_field("payload_byte", want.payload_byte, data);
         compare_field("payload_index", want.payload_index, idx);
         compare_field("payload_length", want.payload_length, length);
         events_checked++;
         if (!$isunknown(kind)) kind_count[kind]++;
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // byte input side
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'd0;

   // event output side
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_command_code;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_index;
   logic [7:0] rsp_payload_length;

   // max_payload write port
   logic       csr_valid       = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_max_payload = 8'd0;

   command_frame_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_payload    (csr_max_payload)
   );

   frame_event_checker board = new();

   // run-wide bookkeeping
   int         send_idle_pct   = 0;
   int         recv_idle_pct   = 0;
   int         bytes_sent      = 0;
   int         settings_used   = 1;
   logic [7:0] max_payload_now = MAX_PAYLOAD_RESET;

   // hold-off request: the driver flips the toggle, the receiver counts the stall itself
   bit         hold_toggle = 1'b0;
   bit         hold_seen   = 1'b0;
   int         hold_left   = 0;
   int         quiet_cycles = 0;

   // receiver: checks each accepted event, then picks next cycle's ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_toggle;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_event(rsp_event_kind, rsp_command_code, rsp_payload_byte,
                              rsp_payload_index, rsp_payload_length);
         if (hold_seen != hold_toggle) begin
            // long stall starts, block should back up into its input
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: a stretch with no handshake on any channel that reaches WATCHDOG_LIMIT ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%t: no handshake for %0d cycles, %0d events outstanding",
                  $time, quiet_cycles, board.pending());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // data bytes lean toward the values the parser cares about
   function automatic logic [7:0] pick_data();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return START_BYTE;
         3: return TAIL_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_other(logic [7:0] avoid);
      logic [7:0] r;
      do r = 8'($urandom); while (r == avoid);
      return r;
   endfunction

   function automatic frame_flaw_type pick_flaw();
      if ($urandom_range(99) < 70) return FLAW_NONE;
      return frame_flaw_type'($urandom_range(3, 1));
   endfunction

   // mostly short payloads, now and then the largest the limit allows
   function automatic int pick_length(logic [7:0] limit);
      int top;
      top = (limit < 12) ? limit : 12;
      if (limit == 0) return 1;
      if ($urandom_range(99) < 4) return limit;
      return $urandom_range(top, 1);
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 20;
            recv_idle_pct = 87;
         end
         1: begin
            send_idle_pct = 87;
            recv_idle_pct = 20;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // offer one byte, with random idle cycles ahead of it, and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_rx_byte(b);
      bytes_sent++;
   endtask

   // stop offering until every predicted event is back, plus the pipeline depth
   task automatic wait_for_events_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_payload(input logic [7:0] value);
      csr_valid       <= 1'b1;
      csr_max_payload <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_max_payload(value);
      max_payload_now = value;
      settings_used++;
      csr_valid <= 1'b0;
   endtask

   task automatic send_write_frame(input logic [7:0] cmd, input int len,
                                   input frame_flaw_type flaw);
      logic [7:0] data;
      logic [7:0] sum;
      sum = 8'd0;
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(cmd);
      send_byte(8'(len));
      for (int i = 0; i < len; i++) begin
         data = pick_data();
         sum  = sum + data;
         send_byte(data);
      end
      if (flaw == FLAW_CHECKSUM || flaw == FLAW_BOTH) sum = sum + 8'($urandom_range(255, 1));
      send_byte(sum);
      send_byte((flaw == FLAW_TAIL || flaw == FLAW_BOTH) ? pick_other(TAIL_BYTE) : TAIL_BYTE);
   endtask

   // read frame: checksum flaw spoils the pad byte, tail flaw the tail byte
   task automatic send_read_frame(input logic [7:0] cmd, input frame_flaw_type flaw);
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(cmd);
      send_byte(8'd0);
      send_byte((flaw == FLAW_CHECKSUM || flaw == FLAW_BOTH) ? pick_other(READ_PAD) : READ_PAD);
      send_byte((flaw == FLAW_TAIL || flaw == FLAW_BOTH) ? pick_other(TAIL_BYTE) : TAIL_BYTE);
   endtask

   // header whose length exceeds the limit, often by exactly one
   task automatic send_overlong_header();
      logic [7:0] len;
      if ($urandom_range(1) == 0) len = max_payload_now + 8'd1;
      else len = 8'($urandom_range(255, int'(max_payload_now) + 1));
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(pick_data());
      send_byte(len);
   endtask

   task automatic send_broken_start();
      send_byte(START_BYTE);
      if ($urandom_range(1) == 0) begin
         // repeated start byte in the second slot must not reopen a frame
         send_byte(START_BYTE);
         send_byte(SECOND_BYTE);
         send_byte(pick_data());
         send_byte(8'd0);
         send_byte(READ_PAD);
         send_byte(TAIL_BYTE);
      end else begin
         send_byte(pick_other(SECOND_BYTE));
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom));
   endtask

   // mostly well-formed frames with random content, the rest broken or noise
   task automatic run_random_phase(input int budget);
      int first_byte;
      int roll;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < budget) begin
         roll = $urandom_range(99);
         if (roll < 50)
            send_write_frame(pick_data(), pick_length(max_payload_now), pick_flaw());
         else if (roll < 65)
            send_read_frame(pick_data(), pick_flaw());
         else if (roll < 75 && max_payload_now != 8'hFF)
            send_overlong_header();
         else if (roll < 85)
            send_broken_start();
         else
            send_noise($urandom_range(6, 1));
      end
   endtask

   // limits after the reset value: both ends, the out-of-range ones and a random one
   logic [7:0] limit_plan [8] = '{8'd98, 8'd0, 8'd1, 8'd255, 8'd253, 8'd254, 8'd98, 8'd12};

   initial begin
      limit_plan[6] = 8'($urandom_range(252, 2));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bytes at the reset limit, no idling
      set_idling(2);
      // read request, command 0x00
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(8'h00);
      send_byte(8'd0);
      send_byte(READ_PAD);
      send_byte(TAIL_BYTE);
      // one-byte write, all ones everywhere, good checksum and tail
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(8'hFF);
      send_byte(8'd1);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(TAIL_BYTE);
      // good checksum, wrong tail: discard
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(8'h80);
      send_byte(8'd1);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      // repeated start byte, then length one past the reset limit
      send_byte(START_BYTE);
      send_byte(START_BYTE);
      send_byte(START_BYTE);
      send_byte(SECOND_BYTE);
      send_byte(8'h33);
      send_byte(MAX_PAYLOAD_RESET + 8'd1);

      // receiver stalls while a long frame keeps coming, then full drain
      hold_toggle <= ~hold_toggle;
      send_write_frame(8'h5A, 30, FLAW_NONE);
      wait_for_events_drained();

      // random phases, idling pattern rotating with each new limit
      for (int p = 0; p < 8; p++) begin
         if (p > 0) write_max_payload(limit_plan[p]);
         set_idling(p % 3);
         run_random_phase(PHASE_BYTES);
         wait_for_events_drained();
      end

      if (board.pending() != 0)
         $display("%t: %0d expected events never arrived", $time, board.pending());
      $display("covered %0d rx bytes under %0d max_payload settings incl 0, 1 and 253..255",
               bytes_sent, settings_used);
      $display("%0d events: payload %0d read %0d write ok %0d checksum error %0d discard %0d",
               board.events_checked, board.kind_count[EV_PAYLOAD], board.kind_count[EV_READ],
               board.kind_count[EV_WRITE_OK], board.kind_count[EV_CS_ERROR],
               board.kind_count[EV_DISCARD]);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
